// File: src/awta_pkg.sv
// Package for the ARGB weighted tap accumulator.
// Holds channel and accumulator widths, shared types and the lane control struct.
// No dependencies.
package awta_pkg;

   localparam int CHAN_COUNT                = 4;
   localparam int CHAN_W                    = 8;
   localparam int PIXEL_W                   = CHAN_COUNT * CHAN_W;
   localparam int WEIGHT_W                  = 16;
   localparam int PROD_W                    = CHAN_W + 1 + WEIGHT_W;
   localparam int ACC_W                     = 32;
   localparam int DEFAULT_WEIGHT_FRAC_BITS  = 14;

   typedef logic [PIXEL_W-1:0]                     pixel_type;
   typedef logic signed [WEIGHT_W-1:0]             weight_type;
   typedef logic [CHAN_W-1:0]                      chan_type;
   typedef logic signed [ACC_W-1:0]                acc_type;
   typedef logic [CHAN_COUNT-1:0][ACC_W-1:0]       sum_vec_type;

   // Pipeline strobes shared by all lanes
   typedef struct packed {
      logic load;     // new transaction enters the product stage
      logic step;     // product stage folds into the accumulator
      logic last;     // product stage holds the final tap
   } lane_ctrl_type;

endpackage

// File: src/awta_if.sv
// Valid/ready channel interfaces for the tap accumulator.
// Depends on awta_pkg for payload types.
interface awta_req_if
   import awta_pkg::*;
   ();
   logic       valid;
   logic       ready;
   pixel_type  pixel;
   weight_type tap_weight;
   logic       last_tap;

   modport source  (output valid, output pixel, output tap_weight, output last_tap,
                    input ready);
   modport sink    (input valid, input pixel, input tap_weight, input last_tap,
                    output ready);
   modport monitor (input valid, input pixel, input tap_weight, input last_tap,
                    input ready);
endinterface

interface awta_rsp_if
   import awta_pkg::*;
   ();
   logic      valid;
   logic      ready;
   pixel_type out_pixel;

   modport source  (output valid, output out_pixel, input ready);
   modport sink    (input valid, input out_pixel, output ready);
   modport monitor (input valid, input out_pixel, input ready);
endinterface

// File: src/argb_weighted_tap_accumulate.sv
// ARGB weighted tap accumulator: multiply-accumulate stage of a separable scaler.
// Depends on awta_pkg, awta_req_if/awta_rsp_if, awta_lane and awta_merge.
//
// Usage:
//   req_chan carries one tap per transaction: a 32-bit pixel (channel 0 in bits
//   7:0), a signed weight with WEIGHT_FRAC_BITS fraction bits, and last_tap.
//   Four lanes multiply their channel by the weight and add into saturating
//   32-bit sums. A tap with last_tap set closes the output pixel: the sums are
//   clamped to 0..255 (fraction truncated), packed, and sent on rsp_chan; the
//   sums restart from zero. Taps without last_tap produce no transaction.
//   Throughput: one tap per clock, closing tap included, if rsp_chan keeps up.
//   Path: a closing tap passes the product, accumulate and clamp/pack registers
//   in turn before its pixel shows on rsp_chan.
//   Stall: a held rsp_chan result does not block taps that do not close a pixel;
//   one more finished pixel waits in the sum stage, and only a further closing
//   tap stalls req_chan until the receiver takes the output.
//   Reset (synchronous): sums cleared, pipeline and output emptied, req ready.
module argb_weighted_tap_accumulate
   import awta_pkg::*;
#(
   parameter int WEIGHT_FRAC_BITS = DEFAULT_WEIGHT_FRAC_BITS
)
(
   input  logic        clock,
   input  logic        reset,
   awta_req_if.sink    req_chan,
   awta_rsp_if.source  rsp_chan
);

   logic          s1_v_ff, s1_v_in;
   logic          s1_last_ff, s1_last_in;
   logic          s2_v_ff, s2_v_in;
   logic          out_v_ff, out_v_in;
   logic          out_free, s2_move, s2_free, s1_go, req_ready, accept;
   lane_ctrl_type lane_ctrl;
   sum_vec_type   sums;

   // stage handshakes, from the output back
   assign out_free  = !out_v_ff || rsp_chan.ready;
   assign s2_move   = s2_v_ff && out_free;
   assign s2_free   = !s2_v_ff || out_free;
   assign s1_go     = s1_v_ff && (!s1_last_ff || s2_free);
   assign req_ready = !s1_v_ff || s1_go;
   assign accept    = req_chan.valid && req_ready;

   assign s1_v_in    = accept || (s1_v_ff && !s1_go);
   assign s1_last_in = accept ? req_chan.last_tap : s1_last_ff;
   assign s2_v_in    = (s1_go && s1_last_ff) || (s2_v_ff && !s2_move);
   assign out_v_in   = s2_move || (out_v_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         s2_v_ff  <= s2_v_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_last_ff <= s1_last_in;
   end

   assign lane_ctrl.load = accept;
   assign lane_ctrl.step = s1_go;
   assign lane_ctrl.last = s1_last_ff;

   // one lane per color channel
   for (genvar c = 0; c < CHAN_COUNT; c++) begin : g_lane
      awta_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (lane_ctrl),
         .chan      (req_chan.pixel[c*CHAN_W +: CHAN_W]),
         .weight    (req_chan.tap_weight),
         .final_sum (sums[c])
      );
   end

   awta_merge #(
      .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
   ) u_merge (
      .clock     (clock),
      .load      (s2_move),
      .sums      (sums),
      .out_pixel (rsp_chan.out_pixel)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = out_v_ff;

endmodule

// File: src/awta_lane.sv
// One channel lane: registered product, saturating accumulator, final sum hold.
// Depends on awta_pkg.
module awta_lane
   import awta_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  lane_ctrl_type ctrl,
   input  chan_type      chan,
   input  weight_type    weight,
   output acc_type       final_sum
);

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   acc_type                  acc_ff, acc_in;
   acc_type                  sum_ff, sum_in;
   logic signed [ACC_W:0]    wide_sum;
   acc_type                  sat_sum;

   // unsigned channel times signed weight
   assign prod_in = PROD_W'($signed({1'b0, chan})) * PROD_W'(weight);

   // saturating add into the 32-bit accumulator
   always_comb begin
      wide_sum = {acc_ff[ACC_W-1], acc_ff}
               + {{(ACC_W + 1 - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      if (wide_sum[ACC_W] != wide_sum[ACC_W-1]) begin
         sat_sum = wide_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                   : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         sat_sum = wide_sum[ACC_W-1:0];
      end
   end

   // accumulator clears once the final tap is folded in
   always_comb begin
      acc_in = acc_ff;
      sum_in = sum_ff;
      if (ctrl.step) begin
         if (ctrl.last) begin
            acc_in = '0;
            sum_in = sat_sum;
         end else begin
            acc_in = sat_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         prod_ff <= prod_in;
      end
      sum_ff <= sum_in;
   end

   assign final_sum = sum_ff;

endmodule

// File: src/awta_merge.sv
// Merge stage: clamps the lane sums to 0..255 and packs the output pixel register.
// Depends on awta_pkg.
module awta_merge
   import awta_pkg::*;
#(
   parameter int WEIGHT_FRAC_BITS = DEFAULT_WEIGHT_FRAC_BITS
)
(
   input  logic        clock,
   input  logic        load,
   input  sum_vec_type sums,
   output pixel_type   out_pixel
);

   pixel_type out_pixel_ff, out_pixel_in;

   // negative -> 0, integer part above 255 -> 255, else drop the fraction
   function automatic chan_type clamp_chan(input logic [ACC_W-1:0] s);
      chan_type res;
      if (s[ACC_W-1]) begin
         res = '0;
      end else if (|s[ACC_W-2:WEIGHT_FRAC_BITS+CHAN_W]) begin
         res = '1;
      end else begin
         res = s[WEIGHT_FRAC_BITS+CHAN_W-1:WEIGHT_FRAC_BITS];
      end
      return res;
   endfunction

   always_comb begin
      for (int c = 0; c < CHAN_COUNT; c++) begin
         out_pixel_in[c*CHAN_W +: CHAN_W] = clamp_chan(sums[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_pixel_ff <= out_pixel_in;
      end
   end

   assign out_pixel = out_pixel_ff;

endmodule

// File: src/awta_checker.sv
// Port-level checker for the tap accumulator, bound to the top level.
// Depends on awta_pkg; watches both handshakes, req last_tap and rsp out_pixel.
module awta_checker
   import awta_pkg::*;
(
   input logic      clock,
   input logic      reset,
   input logic      req_valid,
   input logic      req_ready,
   input logic      req_last_tap,
   input logic      rsp_valid,
   input logic      rsp_ready,
   input pixel_type rsp_out_pixel
);

   logic req_acc;
   assign req_acc = req_valid && req_ready;

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_pixel))
      else $error("rsp transaction changed while stalled");

   // reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // reset leaves the input open
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("req not ready after reset");

   // a closing tap reaches the output when the receiver keeps up
   a_close_latency: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_last_tap ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("closing tap did not produce a pixel in time");

endmodule

bind argb_weighted_tap_accumulate awta_checker u_awta_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .req_last_tap  (req_chan.last_tap),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_out_pixel (rsp_chan.out_pixel)
);

// File: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for argb_weighted_tap_accumulate: directed taps, then random
// filter sequences. Depends on awta_pkg, awta_req_if/awta_rsp_if and the RTL top level.
module testbench;
   import awta_pkg::*;

   localparam int FRAC      = DEFAULT_WEIGHT_FRAC_BITS;
   localparam int W_ONE     = 1 << FRAC;
   localparam int W_MAX     = 32767;
   localparam int W_MIN     = -32768;
   localparam int LATENCY   = 2;
   localparam int RAND_TAPS = 1750;
   localparam int HOLD_AT   = 20;     // output pixel count that starts the long receiver hold
   localparam int HOLD_LEN  = 300;

   // One directed tap; want is used only where typed is set
   typedef struct packed {
      pixel_type  px;
      weight_type wt;
      logic       last;
      logic       typed;
      pixel_type  want;
   } tap_row_type;

   localparam int DIR_ROWS = 19;
   localparam tap_row_type DIRECTED [DIR_ROWS] = '{
      '{32'hFFFF_FFFF, 16'sh4000, 1'b1, 1'b1, 32'hFFFF_FFFF},  // unit weight, single tap
      '{32'hFFFF_FFFF, 16'sh8000, 1'b1, 1'b1, 32'h0000_0000},  // most negative weight
      '{32'h0000_0000, 16'sh7FFF, 1'b1, 1'b1, 32'h0000_0000},  // black pixel
      '{32'h0102_0304, 16'sh7FFF, 1'b1, 1'b1, 32'h0103_0507},  // fraction truncated
      '{32'hFFFF_FFFF, 16'sh0000, 1'b1, 1'b1, 32'h0000_0000},  // zero weight
      '{32'h8080_8080, 16'sh4000, 1'b0, 1'b0, 32'h0000_0000},
      '{32'h8080_8080, 16'sh4000, 1'b1, 1'b1, 32'hFFFF_FFFF},  // 256 clamps to 255
      '{32'h0101_0101, 16'sh4000, 1'b0, 1'b0, 32'h0000_0000},
      '{32'h0101_0101, 16'shFFFF, 1'b1, 1'b1, 32'h0000_0000},  // just under one
      '{32'h0101_0101, 16'sh0001, 1'b0, 1'b0, 32'h0000_0000},
      '{32'h0101_0101, 16'sh4000, 1'b1, 1'b1, 32'h0101_0101},  // just over one
      '{32'h1234_5678, 16'sh7FFF, 1'b0, 1'b0, 32'h0000_0000},
      '{32'hA5C3_E10F, 16'sh8000, 1'b0, 1'b0, 32'h0000_0000},
      '{32'h7F00_FF01, 16'sh2000, 1'b1, 1'b0, 32'h0000_0000},
      '{32'hFF00_FF00, 16'sh4000, 1'b0, 1'b0, 32'h0000_0000},
      '{32'h00FF_00FF, 16'shC000, 1'b1, 1'b0, 32'h0000_0000},  // mixed signs per channel
      '{32'h5555_AAAA, 16'sh5555, 1'b0, 1'b0, 32'h0000_0000},
      '{32'hAAAA_5555, 16'shAAAA, 1'b0, 1'b0, 32'h0000_0000},
      '{32'hFFFF_FFFF, 16'sh3FFF, 1'b1, 1'b0, 32'h0000_0000}
   };

   logic clock;
   logic reset;

   awta_req_if req_chan ();
   awta_rsp_if rsp_chan ();

   argb_weighted_tap_accumulate #(
      .WEIGHT_FRAC_BITS(FRAC)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   // Predictor state and scoreboard
   logic signed [ACC_W-1:0] chan_sum [CHAN_COUNT];
   pixel_type               expected_pixels [$];
   int                      taps_sent;
   int                      pixels_checked;
   int                      sat_events;
   int                      fail_count;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog
   initial begin
      #8_000_000;
      $display("testbench failed");
      $finish;
   end

   // Fold one tap into the channel sums; on a closing tap return the packed pixel
   function automatic logic accumulate_tap(input pixel_type px, input weight_type wt,
                                           input logic last, output pixel_type packed_px);
      longint s;
      longint ip;
      packed_px = '0;
      for (int c = 0; c < CHAN_COUNT; c++) begin
         s = longint'(chan_sum[c]) + longint'(int'(px[CHAN_W*c +: CHAN_W])) * longint'(wt);
         if (s > longint'(32'sh7FFF_FFFF)) begin
            s = longint'(32'sh7FFF_FFFF);
            sat_events++;
         end else if (s < -longint'(64'sh8000_0000)) begin
            s = -longint'(64'sh8000_0000);
            sat_events++;
         end
         chan_sum[c] = s[ACC_W-1:0];
      end
      if (!last)
         return 1'b0;
      for (int c = 0; c < CHAN_COUNT; c++) begin
         if (chan_sum[c] < 0)
            ip = 0;
         else
            ip = longint'(chan_sum[c]) >>> FRAC;
         if (ip > 255)
            ip = 255;
         packed_px[CHAN_W*c +: CHAN_W] = ip[CHAN_W-1:0];
         chan_sum[c] = '0;
      end
      return 1'b1;
   endfunction

   // Offer one tap until accepted, record its expectation, then idle for gap cycles
   task automatic send_tap(input pixel_type px, input weight_type wt, input logic last,
                           input logic typed, input pixel_type want, input int gap);
      pixel_type pred;
      logic      closed;
      req_chan.valid      <= 1'b1;
      req_chan.pixel      <= px;
      req_chan.tap_weight <= wt;
      req_chan.last_tap   <= last;
      do @(posedge clock); while (!req_chan.ready);
      closed = accumulate_tap(px, wt, last, pred);
      if (closed)
         expected_pixels.insert(expected_pixels.size(), typed ? want : pred);
      taps_sent++;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic int pick_gap(input logic steady);
      int r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 75)
         return 0;
      else if (r < 93)
         return $urandom_range(1, 3);
      else if (r < 99)
         return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Stimulus
   initial begin : req_side
      int         seq_idx;
      int         rand_taps;
      int         kind;
      int         len;
      int         span;
      int         wt_int;
      int         sat_sign;
      logic       steady;
      logic       last;
      pixel_type  px;
      req_chan.valid      = 1'b0;
      req_chan.pixel      = '0;
      req_chan.tap_weight = '0;
      req_chan.last_tap   = 1'b0;
      reset               = 1'b1;
      taps_sent           = 0;
      pixels_checked      = 0;
      sat_events          = 0;
      fail_count          = 0;
      for (int c = 0; c < CHAN_COUNT; c++)
         chan_sum[c] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed taps
      for (int i = 0; i < DIR_ROWS; i++)
         send_tap(DIRECTED[i].px, DIRECTED[i].wt, DIRECTED[i].last, DIRECTED[i].typed,
                  DIRECTED[i].want, pick_gap(i < 10));

      // Random filter sequences; the first two drive the sums into saturation
      seq_idx   = 0;
      rand_taps = 0;
      while (rand_taps < RAND_TAPS) begin
         kind     = (seq_idx < 2) ? 99 : $urandom_range(0, 99);
         steady   = ($urandom_range(0, 99) < 30);
         sat_sign = (seq_idx == 1) ? 1 : (seq_idx == 0) ? 0 : $urandom_range(0, 1);
         if (kind < 65)
            len = $urandom_range(1, 16);
         else if (kind < 90)
            len = $urandom_range(1, 24);
         else if (kind < 98)
            len = $urandom_range(17, 64);
         else
            len = $urandom_range(262, 300);
         // the closing sequence stops at the tap budget
         if (len > RAND_TAPS - rand_taps)
            len = RAND_TAPS - rand_taps;
         span = 2 * W_ONE / len;
         for (int t = 0; t < len; t++) begin
            last = (t == len - 1);
            px   = $urandom;
            if (kind < 65) begin
               // scaler-like weights summing near one, with some negative lobes
               wt_int = int'($urandom_range(0, span)) - span / 8;
            end else if (kind < 98) begin
               wt_int = int'($urandom_range(0, 65535)) - 32768;
            end else if (t < len - 3) begin
               px     = 32'hFFFF_FFFF;
               wt_int = sat_sign ? W_MIN : W_MAX;
            end else begin
               // pull back from the limit so saturation versus wrap shows at the output
               wt_int = sat_sign ? $urandom_range(0, W_MAX) : -int'($urandom_range(0, 32768));
            end
            send_tap(px, weight_type'(wt_int), last, 1'b0, '0, pick_gap(steady));
            rand_taps++;
         end
         seq_idx++;
      end
      req_chan.valid <= 1'b0;

      // Drain
      while (expected_pixels.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 6) @(posedge clock);

      if (expected_pixels.size() > 0) begin
         $error("%0d output pixels never arrived", expected_pixels.size());
         fail_count++;
      end
      $display("Run covered %0d taps in %0d random sequences plus directed cases.",
               taps_sent, seq_idx);
      $display("Checked %0d output pixels; %0d channel sums hit the saturation limits.",
               pixels_checked, sat_events);
      if (fail_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

   // Result receiver: random stalls, quiet stretches and one long hold-off
   initial begin : rsp_side
      int        stall;
      int        quiet;
      int        r;
      logic      held;
      pixel_type want;
      rsp_chan.ready = 1'b0;
      stall          = 0;
      quiet          = 0;
      held           = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected output transaction, out_pixel %h", rsp_chan.out_pixel);
               fail_count++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_chan.out_pixel !== want) begin
                  $error("out_pixel mismatch: expected %h, actual %h", want,
                         rsp_chan.out_pixel);
                  fail_count++;
               end
               pixels_checked++;
            end
         end
         if (!held && pixels_checked == HOLD_AT) begin
            held  = 1'b1;
            stall = HOLD_LEN;
         end
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            stall--;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (quiet > 0) begin
               quiet--;
            end else begin
               r = $urandom_range(0, 99);
               if (r < 4)
                  quiet = $urandom_range(40, 150);
               else if (r < 30)
                  stall = $urandom_range(1, 3);
               else if (r < 36)
                  stall = $urandom_range(4, 12);
               else if (r < 38)
                  stall = $urandom_range(20, 60);
            end
         end
      end
   end

endmodule

// File: argb_weighted_tap_accumulate.f
src/awta_pkg.sv
src/awta_if.sv
src/awta_lane.sv
src/awta_merge.sv
src/argb_weighted_tap_accumulate.sv
src/awta_checker.sv
test/testbench.sv
